// ===== rtl/homogeneous_vertex_transform_defines.svh =====
// Assertion macros for the homogeneous vertex transform RTL
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define HVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define HVT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HVT_ASSERT_IMP(lbl, ante, cons, msg)
`define HVT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/hvt_pkg.sv =====
// Shared types, constants and helpers for the homogeneous vertex transform
`default_nettype none

package hvt_pkg;

  // fixed-point format: signed Q(31-FRAC_BITS).FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;

  localparam logic [ELEM_W-1:0] ONE_Q = ELEM_W'(64'd1 << FRAC_BITS);

  // command codes carried in tuser
  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_IDENT = 3'd1,
    CMD_POINT = 3'd2,
    CMD_MIXED = 3'd3,
    CMD_DIR   = 3'd4
  } cmd_t;

  typedef logic [3:0][ELEM_W-1:0] vec_t;   // four Q values, index 0 lowest
  typedef vec_t [3:0]             mat_t;   // row-major, mat[row][col]
  typedef logic [3:0][SUM_W-1:0]  sums_t;  // full-precision dot products

  // per-stage advance strobes shared by all lanes
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctrl_t;

  function automatic mat_t identity_mat();
    mat_t m;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = (r == c) ? ONE_Q : '0;
      end
    end
    return m;
  endfunction

  localparam mat_t IDENTITY_M = identity_mat();

endpackage

`default_nettype wire

// ===== rtl/hvt_lane.sv =====
// One dot-product lane: four multipliers, then a two-level adder tree
`default_nettype none

module hvt_lane
  import hvt_pkg::*;
(
  input  logic                    clk,
  input  pipe_ctrl_t              ctrl,
  input  vec_t                    mrow,   // matrix row for this lane
  input  vec_t                    opnd,   // x, y, z, last-column operand
  output logic signed [SUM_W-1:0] sum
);

  logic signed [PROD_W-1:0] prod [4];
  logic signed [PAIR_W-1:0] pair [2];

  // stage 1: products at full precision
  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= $signed(mrow[k]) * $signed(opnd[k]);
      end
    end
  end

  // stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
  end

  // stage 3: full sum
  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      sum <= SUM_W'(pair[0]) + SUM_W'(pair[1]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hvt_merge.sv =====
// Merge stage: scale, saturate all four lanes and combine the clamp flags
`default_nettype none

module hvt_merge
  import hvt_pkg::*;
(
  input  logic  clk,
  input  logic  load,       // take new lane sums
  input  sums_t sums,
  output vec_t  result,
  output logic  saturated
);

  vec_t       res_next;
  logic [3:0] clamp;

  // floor shift by FRAC_BITS, then clamp to signed 32 bits
  always_comb begin
    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-ELEM_W:0]    hi;
    for (int k = 0; k < 4; k++) begin
      shifted = $signed(sums[k]) >>> FRAC_BITS;
      hi      = shifted[SUM_W-1:ELEM_W-1];
      clamp[k] = !((&hi) || !(|hi));
      if (!clamp[k]) begin
        res_next[k] = shifted[ELEM_W-1:0];
      end else if (shifted[SUM_W-1]) begin
        res_next[k] = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
        res_next[k] = {1'b0, {(ELEM_W-1){1'b1}}};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      result    <= res_next;
      saturated <= |clamp;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/homogeneous_vertex_transform.sv =====
// Homogeneous 4x4 vertex transform: matrix store, four lanes and output merge
//
// Input stream (s_axis): tuser carries the command, tdata the element position,
// the element value and the vertex. Write element and load identity update the
// matrix and return nothing; point, mixed-w point and direction each return
// one transaction on m_axis with the four transformed components and a flag
// that is set when any component was clamped. Other command codes are dropped.
// Matrix updates take effect for the very next transaction.
// A transform accepted on s_axis reaches m_axis through four register stages
// (multiply at the accepting edge, pair add, final add, saturate/merge).
// Throughput: one transaction per cycle unless a receiver stall backs up the
// pipeline, set by the four pipelined multiplier lanes, one per matrix row.
// Reset (rst, synchronous) loads the identity matrix and empties the pipeline.
// When the receiver stalls, the pipeline fills its empty stages first and
// s_axis_tready drops only once every stage holds a result.
`default_nettype none
`include "homogeneous_vertex_transform_defines.svh"

module homogeneous_vertex_transform
  import hvt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: row[1:0], col[3:2], elem_value[35:4], in_x[67:36], in_y[99:68],
  //        in_z[131:100], in_w[163:132], zero pad[167:164]
  input  logic [167:0] s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [127:0] m_axis_tdata,
  // tuser: any_saturated[0]
  output logic         m_axis_tuser
);

  mat_t        matrix;
  cmd_t        cmd;
  logic [1:0]  row;
  logic [1:0]  col;
  logic [31:0] elem_value;
  logic [31:0] in_x, in_y, in_z, in_w;
  logic        s_acc;
  logic        is_xform;
  logic        v1, v2, v3, vo;
  logic        e1, e2, e3, eo;
  pipe_ctrl_t  ctrl;
  sums_t       sums;
  vec_t        result;
  logic        saturated;
  logic        at_limit;

  // unpack the input transaction
  assign cmd        = cmd_t'(s_axis_tuser);
  assign row        = s_axis_tdata[1:0];
  assign col        = s_axis_tdata[3:2];
  assign elem_value = s_axis_tdata[35:4];
  assign in_x       = s_axis_tdata[67:36];
  assign in_y       = s_axis_tdata[99:68];
  assign in_z       = s_axis_tdata[131:100];
  assign in_w       = s_axis_tdata[163:132];

  always_comb begin
    unique case (cmd)
      CMD_POINT, CMD_MIXED, CMD_DIR: is_xform = 1'b1;
      CMD_WRITE, CMD_IDENT:          is_xform = 1'b0;
      default:                       is_xform = 1'b0;
    endcase
  end

  // stage advance: a stage moves when empty or when the next one moves
  assign eo = !vo || m_axis_tready;
  assign e3 = !v3 || eo;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;

  assign s_axis_tready = e1;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign ctrl.en1 = e1;
  assign ctrl.en2 = e2;
  assign ctrl.en3 = e3;

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (e1) v1 <= s_acc && is_xform;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
      if (eo) vo <= v3;
    end
  end

  // matrix store
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= IDENTITY_M;
    end else if (s_acc && cmd == CMD_WRITE) begin
      matrix[row][col] <= elem_value;
    end else if (s_acc && cmd == CMD_IDENT) begin
      matrix <= IDENTITY_M;
    end
  end

  // one lane per matrix row; last operand depends on the mode
  for (genvar r = 0; r < 4; r++) begin : g_lane
    vec_t opnd;

    always_comb begin
      opnd[0] = in_x;
      opnd[1] = in_y;
      opnd[2] = in_z;
      if (cmd == CMD_DIR) begin
        opnd[3] = '0;
      end else if (cmd == CMD_MIXED && r == 3) begin
        opnd[3] = in_w;
      end else begin
        opnd[3] = ONE_Q;
      end
    end

    hvt_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .mrow (matrix[r]),
      .opnd (opnd),
      .sum  (sums[r])
    );
  end

  hvt_merge u_merge (
    .clk       (clk),
    .load      (eo && v3),
    .sums      (sums),
    .result    (result),
    .saturated (saturated)
  );

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = result;
  assign m_axis_tuser  = saturated;

  // any component sitting at a signed 32-bit limit
  always_comb begin
    at_limit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (result[k] == {1'b1, {(ELEM_W-1){1'b0}}} ||
          result[k] == {1'b0, {(ELEM_W-1){1'b1}}}) begin
        at_limit = 1'b1;
      end
    end
  end

  `HVT_ASSERT_NXT(a_ident_load, s_acc && cmd == CMD_IDENT, matrix == IDENTITY_M, "identity load lost")
  `HVT_ASSERT_NXT(a_xform_enters, s_acc && is_xform, v1, "accepted transform not in stage one")
  `HVT_ASSERT_IMP(a_ready_when_free, !v1, s_axis_tready, "input stalled with stage one empty")
  `HVT_ASSERT_IMP(a_sat_flag, vo && !at_limit, !saturated, "clamp flag set without a clamped value")

endmodule

`default_nettype wire

// ===== test/homogeneous_vertex_transform_test.sv =====
// Self-checking stream testbench for the homogeneous vertex transform
`timescale 1ns / 1ps

module homogeneous_vertex_transform_test;
  import hvt_pkg::*;

  // command codes the block drops
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] Q_HALF    = 32'h0000_8000;
  localparam logic [31:0] Q_ULP     = 32'h0000_0001;
  localparam logic [31:0] Q_NEG_ULP = 32'hFFFF_FFFF;

  localparam int RANDOM_ITEMS = 1375;
  localparam int QUIET_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200_000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] elem;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } vertex_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        sat;
  } xform_t;

  // typed = 1: want holds the expected result, read off directly
  typedef struct packed {
    vertex_item_t item;
    logic         typed;
    xform_t       want;
  } stim_row_t;

  localparam xform_t NO_RESULT = '0;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = CMD_WRITE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  logic signed [31:0] model_matrix [4][4];
  xform_t             expected_vertices [$];
  int                 error_count = 0;
  int unsigned        cycle_count = 0;
  int                 cmd_count [8] = '{default: 0};
  int                 checked_vertices = 0;
  int                 saturated_vertices = 0;
  bit                 quiet_tail = 1'b0;

  homogeneous_vertex_transform dut (
    .clk,
    .rst,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed stimulus: identity, extremes, saturation, dropped codes, floor rounding
  stim_row_t directed_rows [25] = '{
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, 32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000,
        32'h1234_5678}, 1'b1, '{32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, ONE_Q, 1'b0}},
    '{'{CMD_DIR, 2'd0, 2'd0, Q_ZERO, 32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000,
        32'h1234_5678}, 1'b1, '{32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, Q_ZERO, 1'b0}},
    '{'{CMD_MIXED, 2'd0, 2'd0, Q_ZERO, 32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000,
        32'hFFFF_4000}, 1'b1,
      '{32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, 32'hFFFF_4000, 1'b0}},
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, Q_MAX, Q_MIN, Q_ULP, Q_ZERO}, 1'b1,
      '{Q_MAX, Q_MIN, Q_ULP, ONE_Q, 1'b0}},
    '{'{CMD_MIXED, 2'd0, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN}, 1'b1,
      '{Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, 1'b0}},
    '{'{CMD_WRITE, 2'd0, 2'd0, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, NO_RESULT},
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b1,
      '{Q_MAX, Q_ZERO, Q_ZERO, ONE_Q, 1'b1}},
    '{'{CMD_WRITE, 2'd1, 2'd1, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, NO_RESULT},
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO}, 1'b1,
      '{Q_ZERO, Q_MIN, Q_ZERO, ONE_Q, 1'b1}},
    '{'{CMD_WRITE, 2'd2, 2'd3, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, NO_RESULT},
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b1,
      '{Q_ZERO, Q_ZERO, Q_MAX, ONE_Q, 1'b0}},
    '{'{CMD_DIR, 2'd0, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b1,
      '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
    '{'{CMD_WRITE, 2'd3, 2'd3, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, NO_RESULT},
    '{'{CMD_MIXED, 2'd0, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN}, 1'b1,
      '{Q_ZERO, Q_ZERO, Q_MAX, Q_MAX, 1'b1}},
    '{'{CMD_RSVD5, 2'd3, 2'd3, Q_ZERO, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b0, NO_RESULT},
    '{'{CMD_RSVD6, 2'd0, 2'd0, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, NO_RESULT},
    '{'{CMD_RSVD7, 2'd2, 2'd1, 32'hDEAD_BEEF, Q_NEG_ULP, Q_NEG_ULP, Q_NEG_ULP,
        Q_NEG_ULP}, 1'b0, NO_RESULT},
    '{'{CMD_WRITE, 2'd3, 2'd2, 32'h0001_8000, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0,
      NO_RESULT},
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_4000,
        Q_ZERO}, 1'b0, NO_RESULT},
    '{'{CMD_MIXED, 2'd0, 2'd0, Q_ZERO, 32'h7000_0000, 32'h8000_0001, Q_ULP,
        32'h4000_0000}, 1'b0, NO_RESULT},
    '{'{CMD_IDENT, 2'd0, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, NO_RESULT},
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, Q_NEG_ULP, Q_MIN, Q_MAX, Q_ZERO}, 1'b1,
      '{Q_NEG_ULP, Q_MIN, Q_MAX, ONE_Q, 1'b0}},
    '{'{CMD_WRITE, 2'd0, 2'd0, Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, NO_RESULT},
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, Q_ULP, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b1,
      '{Q_ZERO, Q_ZERO, Q_ZERO, ONE_Q, 1'b0}},
    // half of minus one ulp floors to minus one ulp
    '{'{CMD_POINT, 2'd0, 2'd0, Q_ZERO, Q_NEG_ULP, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b1,
      '{Q_NEG_ULP, Q_ZERO, Q_ZERO, ONE_Q, 1'b0}}
  };

  function automatic void load_identity();
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        model_matrix[r][c] = (r == c) ? ONE_Q : Q_ZERO;
      end
    end
  endfunction

  // Applies one command to the matrix copy; returns 1 with the transformed
  // vertex for the three transform modes.
  function automatic bit step_transform(input vertex_item_t it, output xform_t res);
    logic signed [31:0] vin [4];
    logic signed [65:0] acc;
    logic signed [65:0] scaled;
    logic [31:0]        comp [4];
    bit                 sat;
    res = '0;
    sat = 1'b0;
    case (it.cmd)
      CMD_WRITE: begin
        model_matrix[it.row][it.col] = it.elem;
        return 1'b0;
      end
      CMD_IDENT: begin
        load_identity();
        return 1'b0;
      end
      CMD_POINT, CMD_MIXED, CMD_DIR: ;
      default: return 1'b0;
    endcase
    vin[0] = it.x;
    vin[1] = it.y;
    vin[2] = it.z;
    for (int r = 0; r < 4; r++) begin
      // last column: translation, w, or nothing for directions
      if (it.cmd == CMD_DIR) vin[3] = Q_ZERO;
      else if (it.cmd == CMD_MIXED && r == 3) vin[3] = it.w;
      else vin[3] = ONE_Q;
      acc = '0;
      for (int c = 0; c < 4; c++) acc = acc + model_matrix[r][c] * vin[c];
      scaled = acc >>> FRAC_BITS;
      // clamp when the upper bits are not a sign extension
      if (scaled[65:31] != {35{scaled[65]}}) begin
        sat = 1'b1;
        comp[r] = scaled[65] ? Q_MIN : Q_MAX;
      end else begin
        comp[r] = scaled[31:0];
      end
    end
    res = '{comp[0], comp[1], comp[2], comp[3], sat};
    return 1'b1;
  endfunction

  // Q16.16 value biased toward the limits and small magnitudes
  function automatic logic [31:0] random_q();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic vertex_item_t random_item();
    vertex_item_t it;
    int           pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) it.cmd = CMD_WRITE;
    else if (pick < 33) it.cmd = CMD_IDENT;
    else if (pick < 58) it.cmd = CMD_POINT;
    else if (pick < 78) it.cmd = CMD_MIXED;
    else if (pick < 95) it.cmd = CMD_DIR;
    else it.cmd = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    it.row  = 2'($urandom());
    it.col  = 2'($urandom());
    it.elem = random_q();
    it.x    = random_q();
    it.y    = random_q();
    it.z    = random_q();
    it.w    = random_q();
    return it;
  endfunction

  // Drives one input transaction, records its expectation once accepted,
  // then sometimes idles the sender.
  task automatic send_item(input vertex_item_t it, input bit typed, input xform_t want);
    xform_t predicted;
    bit     has_result;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {4'b0, it.w, it.z, it.y, it.x, it.elem, it.col, it.row};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    has_result = step_transform(it, predicted);
    if (has_result) expected_vertices.push_back(typed ? want : predicted);
    cmd_count[it.cmd]++;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  // result monitor: compare each output transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    xform_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_vertices.size() == 0) begin
        $error("result transaction with no vertex pending");
        error_count++;
      end else begin
        want = expected_vertices.pop_front();
        check_field("out_x", want.x, m_axis_tdata[31:0]);
        check_field("out_y", want.y, m_axis_tdata[63:32]);
        check_field("out_z", want.z, m_axis_tdata[95:64]);
        check_field("out_w", want.w, m_axis_tdata[127:96]);
        check_field("any_saturated", 32'(want.sat), 32'(m_axis_tuser));
        checked_vertices++;
        if (want.sat) saturated_vertices++;
      end
    end
  end

  // receiver: ready stretches broken by stall bursts, none near the end
  initial begin : receiver
    wait (!rst);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d vertices pending", expected_vertices.size());
      $display("homogeneous_vertex_transform_test failed");
      $finish;
    end
  end

  // main sequence: reset, directed table, random stream, drain
  initial begin : stimulus
    vertex_item_t it;
    int           done;
    load_identity();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    done = 0;
    while (done < RANDOM_ITEMS) begin
      it = random_item();
      if (it.cmd <= CMD_DIR) done++;
      quiet_tail = (done > RANDOM_ITEMS - QUIET_ITEMS);
      send_item(it, 1'b0, NO_RESULT);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d writes, %0d identity, %0d point, %0d mixed, %0d direction, %0d dropped",
             cmd_count[CMD_WRITE], cmd_count[CMD_IDENT], cmd_count[CMD_POINT],
             cmd_count[CMD_MIXED], cmd_count[CMD_DIR],
             cmd_count[CMD_RSVD5] + cmd_count[CMD_RSVD6] + cmd_count[CMD_RSVD7]);
    $display("checked %0d transformed vertices, %0d of them clamped",
             checked_vertices, saturated_vertices);
    if (error_count == 0) begin
      $display("homogeneous_vertex_transform_test passed");
    end else begin
      $display("homogeneous_vertex_transform_test failed");
    end
    $finish;
  end

endmodule
